// File: rtl/core/baro_sensor_compensation_assert.svh
// assertion macros shared by the compensation rtl
`ifndef BARO_SENSOR_COMPENSATION_ASSERT_SVH
`define BARO_SENSOR_COMPENSATION_ASSERT_SVH

// same-cycle implication, clocked on clk, off during reset
`define BSC_ASSERT_IMPLY(lbl, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("implication check failed");

// next-cycle implication, clocked on clk, off during reset
`define BSC_ASSERT_NEXT(lbl, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("next-cycle check failed");

`endif

// File: rtl/core/bsc_pkg.sv
// types, constants and helpers of the barometric sensor compensation
`default_nettype none
package bsc_pkg;

    localparam logic [1:0] CFG_WORD_A = 2'd0;
    localparam logic [1:0] CFG_WORD_B = 2'd1;
    localparam logic [1:0] CFG_WORD_C = 2'd2;

    localparam int DIV_CELLS = 32;

    localparam logic signed [14:0] TEMP_MIN = -15'sd4000;
    localparam logic signed [14:0] TEMP_MAX = 15'sd8500;
    localparam logic [31:0] PRESS_MAX = 32'd131071;

    typedef struct packed {
        logic [31:0]        rem;
        logic [31:0]        num;
        logic [31:0]        quo;
        logic [31:0]        den;
        logic signed [14:0] temp;
        logic               dbl;
        logic               inv;
    } div_t;

    function automatic logic [31:0] mul32(input logic [31:0] a, input logic [31:0] b);
        logic [63:0] prod;
        prod = a * b;
        return prod[31:0];
    endfunction

    function automatic logic [31:0] asr32(input logic [31:0] x, input int unsigned s);
        logic signed [31:0] sx;
        sx = $signed(x) >>> s;
        return $unsigned(sx);
    endfunction

    function automatic logic [31:0] coef_u(input logic [63:0] w, input int unsigned k);
        return {16'd0, w[16*k +: 16]};
    endfunction

    function automatic logic [31:0] coef_s(input logic [63:0] w, input int unsigned k);
        return {{16{w[16*k+15]}}, w[16*k +: 16]};
    endfunction

endpackage
`default_nettype wire

// File: rtl/core/bsc_div_cell.sv
// one restoring-division cell: one quotient bit per cell
`default_nettype none
module bsc_div_cell (
    input  logic          clk,
    input  logic          rst_n,
    input  logic          en,
    input  logic          vld_in,
    input  bsc_pkg::div_t d_in,
    output logic          vld_out,
    output bsc_pkg::div_t d_out
);
    import bsc_pkg::*;

    logic [32:0] sh;
    logic [32:0] diff;
    div_t        data_next;
    div_t        data_reg;
    logic        vld_reg;

    always_comb
    begin
        sh = {d_in.rem, d_in.num[31]};
        diff = sh - {1'b0, d_in.den};
        data_next = d_in;
        data_next.num = {d_in.num[30:0], 1'b0};
        if (!diff[32])
        begin
            data_next.rem = diff[31:0];
            data_next.quo = {d_in.quo[30:0], 1'b1};
        end
        else
        begin
            data_next.rem = sh[31:0];
            data_next.quo = {d_in.quo[30:0], 1'b0};
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            vld_reg <= 1'b0;
        else if (en)
            vld_reg <= vld_in;
    end

    always_ff @(posedge clk)
    begin
        if (en)
            data_reg <= data_next;
    end

    assign vld_out = vld_reg;
    assign d_out   = data_reg;

endmodule
`default_nettype wire

// File: rtl/core/baro_sensor_compensation.sv
// barometric sensor compensation top level: front stages, divider cell row, back stages
//
//  channel | signals                                   | payload
//  s       | s_tvalid s_tready s_tdata[39:0]           | raw temperature, raw pressure
//  m       | m_tvalid m_tready m_tdata[31:0] m_tuser   | temperature, pressure, invalid flag
//  cfg     | cfg_valid cfg_ready cfg_index cfg_data    | calibration word write
//
//  one item per cycle while the output is not stalled; 11 front stages, 32 divider cells, 3 back stages
//  the 32-cell divider row sets the latency, one quotient bit per cell
//  rst_n clears every valid bit and the calibration words
//  a stalled output freezes the whole pipe; cfg is always ready
`default_nettype none
module baro_sensor_compensation (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [39:0] s_tdata,   // raw_temperature[19:0], raw_pressure[39:20]
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [31:0] m_tdata,   // temperature_centi[14:0], pressure_pa[31:15]
    output logic        m_tuser,   // pressure_invalid
    input  logic        cfg_valid,
    output logic        cfg_ready,
    input  logic [1:0]  cfg_index,
    input  logic [63:0] cfg_data
);
    import bsc_pkg::*;

    logic [63:0] cwa_reg, cwb_reg, cwc_reg;
    logic        en;
    logic [31:0] t1, t2, t3, p1, p2, p3, p4, p5, p6, p7, p8, p9;

    logic [11:1] fv_reg;
    logic [31:0] x1_reg, d_reg, m1_reg, m2_reg, a_reg, m3_reg, fine_reg, ap_reg;
    logic [31:0] sq_reg, mp5_reg, mp2_reg, b1_reg, mp5b_reg, mp3_reg, mp2b_reg;
    logic [31:0] b_reg, a2_reg, prod1_reg, b9_reg, var1_reg, num_reg, pm_reg, var1b_reg;
    logic [19:0] adcp1_reg, adcp2_reg, adcp3_reg, adcp4_reg, adcp5_reg, adcp6_reg;
    logic [19:0] adcp7_reg, adcp8_reg, adcp9_reg;
    logic signed [14:0] temp5_reg, temp6_reg, temp7_reg, temp8_reg, temp9_reg;
    logic signed [14:0] temp10_reg, temp11_reg;

    logic [31:0]        tsh;
    logic signed [14:0] temp_next;

    logic        cv  [0:DIV_CELLS];
    div_t        cd  [0:DIV_CELLS];

    logic               bv12_reg, bv13_reg;
    logic [31:0]        q3m_reg, mp8_reg, p12_reg, m9_reg, mp8b_reg, p13_reg;
    logic signed [14:0] temp12_reg, temp13_reg;
    logic               inv12_reg, inv13_reg;
    logic [31:0]        pdiv, q3, pfin;

    logic               out_vld_reg;
    logic signed [14:0] out_temp_reg;
    logic [16:0]        out_pa_reg;
    logic               out_inv_reg;

    assign en        = !out_vld_reg || m_tready;
    assign s_tready  = en;
    assign cfg_ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cwa_reg <= '0;
            cwb_reg <= '0;
            cwc_reg <= '0;
        end
        else if (cfg_valid)
        begin
            unique case (cfg_index)
                CFG_WORD_A: cwa_reg <= cfg_data;
                CFG_WORD_B: cwb_reg <= cfg_data;
                CFG_WORD_C: cwc_reg <= cfg_data;
                default: ;
            endcase
        end
    end

    assign t1 = coef_u(cwa_reg, 0);
    assign t2 = coef_s(cwa_reg, 1);
    assign t3 = coef_s(cwa_reg, 2);
    assign p1 = coef_u(cwa_reg, 3);
    assign p2 = coef_s(cwb_reg, 0);
    assign p3 = coef_s(cwb_reg, 1);
    assign p4 = coef_s(cwb_reg, 2);
    assign p5 = coef_s(cwb_reg, 3);
    assign p6 = coef_s(cwc_reg, 0);
    assign p7 = coef_s(cwc_reg, 1);
    assign p8 = coef_s(cwc_reg, 2);
    assign p9 = coef_s(cwc_reg, 3);

    // temperature rounding and clamp
    always_comb
    begin
        tsh = asr32(mul32(fine_reg, 32'd5) + 32'd128, 8);
        if ($signed(tsh) < $signed({{17{TEMP_MIN[14]}}, TEMP_MIN}))
            temp_next = TEMP_MIN;
        else if ($signed(tsh) > $signed({{17{TEMP_MAX[14]}}, TEMP_MAX}))
            temp_next = TEMP_MAX;
        else
            temp_next = $signed(tsh[14:0]);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            fv_reg <= '0;
        else if (en)
            fv_reg <= {fv_reg[10:1], s_tvalid};
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            x1_reg    <= {15'd0, s_tdata[19:3]} - {t1[30:0], 1'b0};
            d_reg     <= {16'd0, s_tdata[19:4]} - t1;
            adcp1_reg <= s_tdata[39:20];

            m1_reg    <= mul32(x1_reg, t2);
            m2_reg    <= mul32(d_reg, d_reg);
            adcp2_reg <= adcp1_reg;

            a_reg     <= asr32(m1_reg, 11);
            m3_reg    <= mul32(asr32(m2_reg, 12), t3);
            adcp3_reg <= adcp2_reg;

            fine_reg  <= a_reg + asr32(m3_reg, 14);
            adcp4_reg <= adcp3_reg;

            temp5_reg <= temp_next;
            ap_reg    <= asr32(fine_reg, 1) - 32'd64000;
            adcp5_reg <= adcp4_reg;

            sq_reg    <= mul32(asr32(ap_reg, 2), asr32(ap_reg, 2));
            mp5_reg   <= mul32(ap_reg, p5);
            mp2_reg   <= mul32(p2, ap_reg);
            temp6_reg <= temp5_reg;
            adcp6_reg <= adcp5_reg;

            b1_reg    <= mul32(asr32(sq_reg, 11), p6);
            mp3_reg   <= mul32(p3, asr32(sq_reg, 13));
            mp5b_reg  <= mp5_reg;
            mp2b_reg  <= mp2_reg;
            temp7_reg <= temp6_reg;
            adcp7_reg <= adcp6_reg;

            b_reg     <= asr32(b1_reg + {mp5b_reg[30:0], 1'b0}, 2) + {p4[15:0], 16'd0};
            a2_reg    <= asr32(asr32(mp3_reg, 3) + asr32(mp2b_reg, 1), 18);
            temp8_reg <= temp7_reg;
            adcp8_reg <= adcp7_reg;

            prod1_reg  <= mul32(32'd32768 + a2_reg, p1);
            b9_reg     <= b_reg;
            temp9_reg  <= temp8_reg;
            adcp9_reg  <= adcp8_reg;

            var1_reg   <= asr32(prod1_reg, 15);
            num_reg    <= 32'd1048576 - {12'd0, adcp9_reg} - asr32(b9_reg, 12);
            temp10_reg <= temp9_reg;

            pm_reg     <= mul32(num_reg, 32'd3125);
            var1b_reg  <= var1_reg;
            temp11_reg <= temp10_reg;
        end
    end

    always_comb
    begin
        cv[0]      = fv_reg[11];
        cd[0].rem  = '0;
        cd[0].num  = pm_reg[31] ? pm_reg : {pm_reg[30:0], 1'b0};
        cd[0].quo  = '0;
        cd[0].den  = var1b_reg;
        cd[0].temp = temp11_reg;
        cd[0].dbl  = pm_reg[31];
        cd[0].inv  = (var1b_reg == 32'd0);
    end

    genvar gi;
    generate
        for (gi = 0; gi < DIV_CELLS; gi++)
        begin : g_div
            bsc_div_cell u_cell (
                .clk     (clk),
                .rst_n   (rst_n),
                .en      (en),
                .vld_in  (cv[gi]),
                .d_in    (cd[gi]),
                .vld_out (cv[gi+1]),
                .d_out   (cd[gi+1])
            );
        end
    endgenerate

    assign pdiv = cd[DIV_CELLS].dbl ? {cd[DIV_CELLS].quo[30:0], 1'b0} : cd[DIV_CELLS].quo;
    assign q3   = {3'd0, pdiv[31:3]};
    assign pfin = p13_reg + asr32(asr32(m9_reg, 12) + asr32(mp8b_reg, 13) + p7, 4);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            bv12_reg    <= 1'b0;
            bv13_reg    <= 1'b0;
            out_vld_reg <= 1'b0;
        end
        else if (en)
        begin
            bv12_reg    <= cv[DIV_CELLS];
            bv13_reg    <= bv12_reg;
            out_vld_reg <= bv13_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            q3m_reg    <= mul32(q3, q3);
            mp8_reg    <= mul32({2'd0, pdiv[31:2]}, p8);
            p12_reg    <= pdiv;
            temp12_reg <= cd[DIV_CELLS].temp;
            inv12_reg  <= cd[DIV_CELLS].inv;

            m9_reg     <= mul32(p9, {13'd0, q3m_reg[31:13]});
            mp8b_reg   <= mp8_reg;
            p13_reg    <= p12_reg;
            temp13_reg <= temp12_reg;
            inv13_reg  <= inv12_reg;

            out_temp_reg <= temp13_reg;
            out_inv_reg  <= inv13_reg;
            if (inv13_reg)
                out_pa_reg <= '0;
            else if (pfin > PRESS_MAX)
                out_pa_reg <= PRESS_MAX[16:0];
            else
                out_pa_reg <= pfin[16:0];
        end
    end

    assign m_tvalid = out_vld_reg;
    assign m_tdata  = {out_pa_reg, out_temp_reg};
    assign m_tuser  = out_inv_reg;

`include "baro_sensor_compensation_assert.svh"

    `BSC_ASSERT_IMPLY(a_inv_zero, out_vld_reg && out_inv_reg, out_pa_reg == 17'd0)
    `BSC_ASSERT_IMPLY(a_temp_range, out_vld_reg,
        out_temp_reg >= TEMP_MIN && out_temp_reg <= TEMP_MAX)
    `BSC_ASSERT_NEXT(a_stall_freeze, !en, $stable(fv_reg) && $stable(bv12_reg))
    `BSC_ASSERT_NEXT(a_div_feed, en && cv[DIV_CELLS], bv12_reg)

endmodule
`default_nettype wire
